// ===== sv/c2d_pkg.sv =====
// Shared types and constants of the 3x3 grey convolution block.
// Used by the front end, the job queue, the back end and the top level.
package c2d_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int DIM_W      = 12;
	localparam int POS_W      = $clog2(MAX_HEIGHT + 1);
	localparam int PIX_W      = 8;
	localparam int TAP_W      = 16;
	localparam int NTAPS      = 9;
	localparam int PROD_W     = PIX_W + 1 + TAP_W;
	localparam int SUM_W      = PROD_W + 4;
	localparam int FRAC_W     = 8;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		REG_TAPS_LOW   = 3'd0,
		REG_TAPS_MID   = 3'd1,
		REG_TAP_LAST   = 3'd2,
		REG_WIDTH      = 3'd3,
		REG_HEIGHT     = 3'd4,
		REG_SAME_SIZE  = 3'd5
	} cfg_reg_t;

	typedef logic [NTAPS-1:0][PIX_W-1:0] win_t;
	typedef logic [NTAPS-1:0][TAP_W-1:0] taps_t;

	typedef struct packed {
		win_t win;
		logic need0;
		logic need1;
		logic fe0;
		logic fe1;
	} job_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             same_size;
	} geom_t;

endpackage

// ===== sv/c2d_front.sv =====
// Front end: accepts pixels and drain ticks, tracks the raster position,
// holds the two line stores and the 3x3 window, and issues jobs. Uses c2d_pkg.
module c2d_front import c2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  geom_t            geom,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_func,
	input  logic [PIX_W-1:0] in_pixel,
	output logic             push,
	output job_t             push_job,
	input  logic             q_full
);

	logic [DIM_W-1:0] w, h;
	logic [POS_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [DIM_W-1:0] pend_q;

	logic             acc;
	logic             live;
	logic [POS_W-1:0] r;
	logic [COL_W-1:0] c;
	logic             c_last, r_last;
	logic             need0, need1, fe0, fe1;
	logic [DIM_W-1:0] pend_dec;

	logic             v_s1, clr_s1, r1_s1, r2_s1, par_s1;
	logic             need0_s1, need1_s1, fe0_s1, fe1_s1;
	logic [PIX_W-1:0] bot_s1, rd0_s1, rd1_s1;
	win_t             win_q, win_nxt;
	logic [PIX_W-1:0] col0, col1;
	logic             adv, has_job;

	logic [PIX_W-1:0] mem0 [MAX_WIDTH];
	logic [PIX_W-1:0] mem1 [MAX_WIDTH];

	always_comb begin
		w = geom.width;
		if (geom.width < DIM_W'(3)) w = DIM_W'(3);
		else if (geom.width > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
		h = geom.height;
		if (geom.height < DIM_W'(3)) h = DIM_W'(3);
		else if (geom.height > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
	end

	assign acc = in_valid && in_ready;
	assign pend_dec = pend_q - DIM_W'(1);

	always_comb begin
		live = 1'b1;
		r = row_q;
		c = col_q;
		if (!in_func && pend_q != '0) begin
			r = '0;
			c = '0;
		end
		if (in_func && pend_q == '0) live = 1'b0;
		c_last = ({1'b0, c} >= w - DIM_W'(1));
		r_last = (r >= POS_W'(h - DIM_W'(1)));
		need0 = 1'b0;
		need1 = 1'b0;
		fe0 = 1'b0;
		fe1 = 1'b0;
		if (in_func) begin
			need0 = (c != '0);
			need1 = c_last;
			fe1 = 1'b1;
		end else if (geom.same_size) begin
			need0 = (r != '0) && (c != '0);
			need1 = (r != '0) && c_last;
		end else begin
			need0 = (r >= POS_W'(2)) && (c >= COL_W'(2));
			fe0 = r_last && c_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pend_q <= '0;
		end else if (acc && live) begin
			if (in_func) begin
				if (pend_dec == '0 || c_last) begin
					pend_q <= '0;
					row_q <= '0;
					col_q <= '0;
				end else begin
					pend_q <= pend_dec;
					col_q <= c + COL_W'(1);
				end
			end else begin
				pend_q <= '0;
				if (c_last) begin
					col_q <= '0;
					if (r_last) begin
						if (geom.same_size) begin
							row_q <= r + POS_W'(1);
							pend_q <= w;
						end else begin
							row_q <= '0;
						end
					end else begin
						row_q <= r + POS_W'(1);
					end
				end else begin
					row_q <= r;
					col_q <= c + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && live) begin
			rd0_s1 <= mem0[c];
			rd1_s1 <= mem1[c];
			if (!in_func && !r[0]) mem0[c] <= in_pixel;
			if (!in_func && r[0]) mem1[c] <= in_pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && live) begin
			clr_s1 <= (c == '0);
			r1_s1 <= (r != '0);
			r2_s1 <= (r >= POS_W'(2));
			par_s1 <= r[0];
			bot_s1 <= in_func ? '0 : in_pixel;
			need0_s1 <= need0;
			need1_s1 <= need1;
			fe0_s1 <= fe0;
			fe1_s1 <= fe1;
		end
	end

	assign has_job = need0_s1 || need1_s1;
	assign adv = v_s1 && (!has_job || !q_full);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= acc && live;
	end

	always_comb begin
		win_t base;
		base = clr_s1 ? '0 : win_q;
		col0 = r2_s1 ? (par_s1 ? rd1_s1 : rd0_s1) : '0;
		col1 = r1_s1 ? (par_s1 ? rd0_s1 : rd1_s1) : '0;
		for (int b = 0; b < 3; b++) begin
			win_nxt[b*3+0] = base[b*3+1];
			win_nxt[b*3+1] = base[b*3+2];
		end
		win_nxt[2] = col0;
		win_nxt[5] = col1;
		win_nxt[8] = bot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) win_q <= '0;
		else if (adv) win_q <= win_nxt;
	end

	assign push = adv && has_job;
	assign push_job = '{win: win_nxt, need0: need0_s1, need1: need1_s1,
		fe0: fe0_s1, fe1: fe1_s1};

endmodule

// ===== sv/c2d_queue.sv =====
// Short first-word-fall-through job queue between front and back end.
// Uses c2d_pkg for the job type and depth.
module c2d_queue import c2d_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic valid,
	output job_t head
);

	job_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + QPTR_W'(1);
			if (pop) rp_q <= rp_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("job queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("job queue read while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("job queue count out of range");

endmodule

// ===== sv/c2d_back.sv =====
// Back end: takes jobs from the queue, multiplies the window by the taps,
// sums, truncates toward zero and drives the output register. Uses c2d_pkg.
module c2d_back import c2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  taps_t            taps,
	input  logic             q_valid,
	input  job_t             q_head,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_result,
	output logic             out_last
);

	logic                     sel_q;
	logic                     shift, fe, last;
	logic                     en_o, en2, enp;
	logic                     vp_s1, fe_s1, v_s2, fe_s2;
	logic signed [PROD_W-1:0] prod_s1 [NTAPS];
	logic signed [SUM_W-1:0]  sum_s2, sum;
	logic [SUM_W-1:0]         mag, quo;

	assign shift = !(q_head.need0 && !sel_q);
	assign fe = shift ? q_head.fe1 : q_head.fe0;
	assign last = !(q_head.need0 && q_head.need1) || sel_q;

	assign en_o = !out_valid || out_ready;
	assign en2 = !v_s2 || en_o;
	assign enp = !vp_s1 || en2;
	assign q_pop = enp && q_valid && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
			vp_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (enp && q_valid) sel_q <= !last;
			if (enp) vp_s1 <= q_valid;
			if (en2) v_s2 <= vp_s1;
			if (en_o) out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (enp && q_valid) begin
			fe_s1 <= fe;
			for (int b = 0; b < 3; b++) begin
				for (int e = 0; e < 3; e++) begin
					logic [PIX_W-1:0] px;
					px = '0;
					if (!shift) px = q_head.win[b*3+e];
					else if (e < 2) px = q_head.win[b*3+e+1];
					prod_s1[b*3+e] <= $signed({1'b0, px}) * $signed(taps[b*3+e]);
				end
			end
		end
	end

	always_comb begin
		sum = '0;
		for (int k = 0; k < NTAPS; k++) sum = sum + SUM_W'(prod_s1[k]);
	end

	always_ff @(posedge clk) begin
		if (en2 && vp_s1) begin
			sum_s2 <= sum;
			fe_s2 <= fe_s1;
		end
	end

	assign mag = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
	assign quo = mag >> FRAC_W;

	always_ff @(posedge clk) begin
		if (en_o && v_s2) begin
			out_result <= sum_s2[SUM_W-1] ? PIX_W'(-quo) : quo[PIX_W-1:0];
			out_last <= fe_s2;
		end
	end

endmodule

// ===== sv/conv2d_3x3_gray_top.sv =====
// Top level of the streaming 3x3 grey convolution: configuration registers,
// front end, job queue and back end. Depends on c2d_pkg and the c2d modules.
// Throughput: one item per cycle unless the job queue is full; an item
// with two results holds the back end's multiplier stage for both of
// them, absorbed by the four-entry queue.
// Reset: arst_n clears position, drain count, window and pipeline valids;
// registers reset to zero taps, 640x480, same-size mode. No clearing pass.
module conv2d_3x3_gray_top import c2d_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // pixel[7:0]
	input  logic             s_tuser,   // func[0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // result[7:0]
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [2:0]       cfg_index,
	input  logic [63:0]      cfg_data
);

	logic [63:0]      taps_low_q, taps_mid_q;
	logic [15:0]      tap_last_q;
	geom_t            geom_q;
	taps_t            taps;
	logic             push, q_full, q_pop, q_valid;
	job_t             push_job, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_low_q <= '0;
			taps_mid_q <= '0;
			tap_last_q <= '0;
			geom_q <= '{width: DIM_W'(640), height: DIM_W'(480), same_size: 1'b1};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_TAPS_LOW:  taps_low_q <= cfg_data;
				REG_TAPS_MID:  taps_mid_q <= cfg_data;
				REG_TAP_LAST:  tap_last_q <= cfg_data[15:0];
				REG_WIDTH:     geom_q.width <= cfg_data[DIM_W-1:0];
				REG_HEIGHT:    geom_q.height <= cfg_data[DIM_W-1:0];
				REG_SAME_SIZE: geom_q.same_size <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign taps = {tap_last_q, taps_mid_q, taps_low_q};

	c2d_front u_front (
		.clk(clk), .arst_n(arst_n), .geom(geom_q),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_func(s_tuser), .in_pixel(s_tdata),
		.push(push), .push_job(push_job), .q_full(q_full)
	);

	c2d_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(push_job),
		.full(q_full), .pop(q_pop), .valid(q_valid), .head(q_head)
	);

	c2d_back u_back (
		.clk(clk), .arst_n(arst_n), .taps(taps),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_result(m_tdata), .out_last(m_tlast)
	);

endmodule

// ===== tb/conv2d_3x3_gray_checker.sv =====
`timescale 1ns / 100ps
// Checker for the 3x3 grey convolution: predicts every result from the accepted
// pixel, drain and configuration transfers and compares it with the output stream.
// Depends on c2d_pkg for the register indexes and the size limits.
module conv2d_3x3_gray_checker import c2d_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          outstanding,
	output int          results_seen
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} conv_out_t;

	conv_out_t   outq[$];
	logic [63:0] taps_lo, taps_mi;
	logic [15:0] tap_hi;
	logic [11:0] cfg_w, cfg_h;
	logic        same;
	logic [7:0]  lines [0:2*MAX_WIDTH-1];
	logic [7:0]  win [0:8];
	int unsigned row, col, drain_left;

	assign outstanding = outq.size();

	function automatic int unsigned eff_w();
		if (cfg_w < 3) return 3;
		if (cfg_w > MAX_WIDTH) return MAX_WIDTH;
		return cfg_w;
	endfunction

	function automatic int unsigned eff_h();
		if (cfg_h < 3) return 3;
		if (cfg_h > MAX_HEIGHT) return MAX_HEIGHT;
		return cfg_h;
	endfunction

	function automatic int unsigned line_addr(int unsigned slot, int unsigned c);
		return (slot & 1) * MAX_WIDTH + (c < MAX_WIDTH ? c : MAX_WIDTH - 1);
	endfunction

	function automatic longint tap_at(int k);
		logic signed [15:0] t;
		if (k < 4) t = taps_lo[16*k +: 16];
		else if (k < 8) t = taps_mi[16*(k-4) +: 16];
		else t = tap_hi;
		return longint'(t);
	endfunction

	function automatic logic [7:0] conv_sum(int shift);
		longint acc;
		longint px;
		acc = 0;
		for (int b = 0; b < 3; b++) begin
			for (int e = 0; e < 3; e++) begin
				px = (e + shift < 3) ? longint'(win[b*3 + e + shift]) : 0;
				acc += px * tap_at(b*3 + e);
			end
		end
		acc = acc / 256;
		return acc[7:0];
	endfunction

	task automatic load_col(int unsigned r, int unsigned c, logic [7:0] bottom);
		logic [7:0] column [0:2];
		if (c == 0) for (int i = 0; i < 9; i++) win[i] = 0;
		column[0] = r >= 2 ? lines[line_addr(r, c)] : 8'd0;
		column[1] = r >= 1 ? lines[line_addr(r + 1, c)] : 8'd0;
		column[2] = bottom;
		for (int b = 0; b < 3; b++) begin
			win[b*3]     = win[b*3 + 1];
			win[b*3 + 1] = win[b*3 + 2];
			win[b*3 + 2] = column[b];
		end
	endtask

	task automatic predict(logic is_drain, logic [7:0] pix);
		int unsigned w, h, r, c;
		w = eff_w();
		h = eff_h();
		if (is_drain) begin
			if (drain_left == 0) return;
			r = row;
			c = col;
			load_col(r, c, 8'd0);
			if (c >= 1) outq.push_back('{conv_sum(0), 1'b0});
			if (c >= w - 1) outq.push_back('{conv_sum(1), 1'b1});
			drain_left--;
			if (drain_left == 0 || c >= w - 1) begin
				drain_left = 0;
				row = 0;
				col = 0;
			end else begin
				col = c + 1;
			end
			return;
		end
		if (drain_left != 0) begin
			drain_left = 0;
			row = 0;
			col = 0;
		end
		r = row;
		c = col;
		load_col(r, c, pix);
		lines[line_addr(r, c)] = pix;
		if (same) begin
			if (r >= 1 && c >= 1) outq.push_back('{conv_sum(0), 1'b0});
			if (r >= 1 && c >= w - 1) outq.push_back('{conv_sum(1), 1'b0});
		end else if (r >= 2 && c >= 2) begin
			outq.push_back('{conv_sum(0), (r >= h - 1 && c >= w - 1)});
		end
		if (c >= w - 1) begin
			col = 0;
			if (r >= h - 1) begin
				if (same) begin
					row = r + 1;
					drain_left = w;
				end else begin
					row = 0;
				end
			end else begin
				row = r + 1;
			end
		end else begin
			col = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		conv_out_t exp_out;
		if (!arst_n) begin
			taps_lo = 0;
			taps_mi = 0;
			tap_hi = 0;
			cfg_w = 640;
			cfg_h = 480;
			same = 1;
			for (int i = 0; i < 2*MAX_WIDTH; i++) lines[i] = 0;
			for (int i = 0; i < 9; i++) win[i] = 0;
			row = 0;
			col = 0;
			drain_left = 0;
			outq.delete();
			errors = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (outq.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result transfer: result=%0h last=%0b",
							m_tdata, m_tlast);
				end else begin
					exp_out = outq.pop_front();
					if (exp_out.value !== m_tdata || exp_out.last !== m_tlast) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: expected result=%0h last=%0b, got result=%0h last=%0b",
								exp_out.value, exp_out.last, m_tdata, m_tlast);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_TAPS_LOW:  taps_lo = cfg_data;
					REG_TAPS_MID:  taps_mi = cfg_data;
					REG_TAP_LAST:  tap_hi = cfg_data[15:0];
					REG_WIDTH:     cfg_w = cfg_data[11:0];
					REG_HEIGHT:    cfg_h = cfg_data[11:0];
					REG_SAME_SIZE: same = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) predict(s_tuser, s_tdata);
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Top of the 3x3 grey convolution testbench: clock, reset, stimulus and verdict.
// Depends on c2d_pkg, conv2d_3x3_gray_top and conv2d_3x3_gray_checker.
module tb;
	import c2d_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic [7:0]  s_tdata = 0;
	logic        s_tuser = 0;
	logic        m_tready = 0;
	logic        cfg_valid = 0;
	logic [2:0]  cfg_index = 0;
	logic [63:0] cfg_data = 0;
	logic        s_tready, m_tvalid, m_tlast, cfg_ready;
	logic [7:0]  m_tdata;
	int          errors, outstanding, results_seen;
	int          s_gap, r_gap, hold_left, items, frames, holds;

	conv2d_3x3_gray_top DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	conv2d_3x3_gray_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .errors(errors), .outstanding(outstanding),
		.results_seen(results_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= $urandom_range(99) >= r_gap;
			end
		end
	end

	task automatic push_item(logic is_drain, logic [7:0] pix);
		if ($urandom_range(99) < s_gap) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < s_gap);
		end
		s_tvalid <= 1'b1;
		s_tuser <= is_drain;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		items++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		repeat (2) @(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_taps(logic [63:0] lo, logic [63:0] mid, logic [15:0] last);
		write_reg(REG_TAPS_LOW, lo);
		write_reg(REG_TAPS_MID, mid);
		write_reg(REG_TAP_LAST, {$urandom, 16'($urandom_range(65535)), last});
	endtask

	task automatic set_geom(logic [11:0] w, logic [11:0] h, logic same);
		write_reg(REG_WIDTH, {$urandom, 20'($urandom_range(1048575)), w});
		write_reg(REG_HEIGHT, {$urandom, 20'($urandom_range(1048575)), h});
		write_reg(REG_SAME_SIZE, {$urandom, 31'($urandom), same});
	endtask

	// Sends one frame of eff_w x eff_h pixels and then the given number of drain
	// ticks; pix_kind 0 random, 1 all zero, 2 all full scale, 3 alternating.
	task automatic send_frame(int eff_w, int eff_h, int ticks, int pix_kind, int noise);
		logic [7:0] p;
		for (int r = 0; r < eff_h; r++) begin
			for (int c = 0; c < eff_w; c++) begin
				if ($urandom_range(99) < noise) push_item(1'b1, 8'($urandom));
				case (pix_kind)
					1: p = 8'h00;
					2: p = 8'hFF;
					3: p = ((r + c) & 1) ? 8'hFF : 8'h00;
					default: p = 8'($urandom);
				endcase
				push_item(1'b0, p);
			end
		end
		for (int i = 0; i < ticks; i++) push_item(1'b1, 8'($urandom));
		frames++;
	endtask

	task automatic random_frame(ref logic clean, input int big);
		int w, h, ticks;
		logic same;
		w = big ? 3 + $urandom_range(29) : 3 + $urandom_range(7);
		h = 3 + $urandom_range(3);
		same = 1'($urandom_range(1));
		if (clean) begin
			wait_drained();
			case ($urandom_range(3))
				0: set_taps({$urandom, $urandom}, {$urandom, $urandom}, 16'($urandom));
				1: set_taps({4{16'(int'($urandom_range(1023)) - 512)}},
					{4{16'(int'($urandom_range(1023)) - 512)}},
					16'($urandom_range(511)));
				default: ;
			endcase
			set_geom(12'(w), 12'(h), same);
		end else begin
			w = u_checker.eff_w();
			h = u_checker.eff_h();
			same = u_checker.same;
		end
		ticks = same ? w : $urandom_range(2);
		clean = 1;
		if (same && $urandom_range(5) == 0) begin
			ticks = $urandom_range(w - 1);
			clean = 0;
		end
		if (big && hold_left == 0 && (holds == 0 || $urandom_range(15) == 0)) begin
			hold_left = 400;
			holds++;
		end
		send_frame(w, h, ticks, 0, 4);
		if (!same) clean = 1;
	endtask

	initial begin
		logic clean;
		s_gap = 15;
		r_gap = 81;
		hold_left = 0;
		items = 0;
		frames = 0;
		holds = 0;
		clean = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part: tap and pixel extremes, clamping, drain corner cases.
		set_taps({4{16'h7FFF}}, {4{16'h7FFF}}, 16'h7FFF);
		set_geom(12'd2, 12'd0, 1'b1);
		send_frame(3, 3, 3, 2, 0);
		wait_drained();
		set_taps({4{16'h8000}}, {4{16'h8000}}, 16'h8000);
		set_geom(12'd3, 12'd3, 1'b0);
		send_frame(3, 3, 1, 3, 0);
		wait_drained();
		set_taps(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0100, 16'h0000);
		set_geom(12'd4, 12'd3, 1'b1);
		send_frame(4, 3, 2, 0, 0);
		wait_drained();
		set_geom(12'd6, 12'd3, 1'b1);
		for (int i = 0; i < 3; i++) push_item(1'b1, 8'($urandom));
		push_item(1'b0, 8'hFF);
		push_item(1'b0, 8'h00);
		push_item(1'b0, 8'h80);
		for (int i = 0; i < 15; i++) push_item(1'b0, 8'($urandom));
		push_item(1'b1, 8'($urandom));
		push_item(1'b0, 8'($urandom));
		send_frame(6, 3, 6, 1, 0);

		while (items < 2000) begin
			if (items >= 700 && s_gap == 15) begin
				s_gap = 81;
				r_gap = 15;
			end
			if (items >= 1400 && s_gap == 81) begin
				s_gap = 0;
				r_gap = 0;
			end
			random_frame(clean, s_gap == 0);
		end
		wait_drained();

		$display("Covered %0d input transfers in %0d frames, %0d result transfers checked.",
			items, frames, results_seen);
		$display("Frames 3 to 32 wide and 3 to 6 tall in both padding modes, with drains.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/c2d_pkg.sv
sv/c2d_front.sv
sv/c2d_queue.sv
sv/c2d_back.sv
sv/conv2d_3x3_gray_top.sv
tb/conv2d_3x3_gray_checker.sv
tb/tb.sv
